// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the dispatcher.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define PTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low)
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/ptd_pkg.sv -----
// Package for the periodic task dispatcher: sizes, codes, FSM state and
// the structs passed between the table, the adder unit and the sequencer.
// No dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int NUM_TASKS = 8;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int TIME_W    = 32;
    localparam int ID_W      = 3;
    localparam int PROD_W    = 2 * TIME_W;

    // floor(p / 3) == (p * 0xAAAAAAAB) >> 33 for every 32-bit p
    localparam logic [TIME_W-1:0] THIRD_RECIP = 32'hAAAA_AAAB;
    localparam int                THIRD_SHIFT = 33;

    // input action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PASS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_MUL,
        S_LOAD_WR,
        S_CHECK,
        S_UPDATE,
        S_FINISH
    } t_state;

    // shared adder operation
    typedef enum logic {
        ALU_SLIP,   // due + period/3, slip window
        ALU_NEXT    // (due or now) + period
    } t_alu_op;

    typedef struct packed {
        logic              load;     // write whole entry, due cleared
        logic              upd;      // write due time only
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] third;
        logic              rt;
        logic              valid;
        logic [TIME_W-1:0] due;
    } t_tbl_wr;

    typedef struct packed {
        logic              valid;
        logic              rt;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] third;
        logic [TIME_W-1:0] due;
    } t_tbl_rd;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              now_lt_sum;
        logic              now_gt_due;
    } t_alu_res;

endpackage

// ----- sv/ptd_in_if.sv -----
// Input channel of the dispatcher: valid/ready plus one task or pass item.
// Depends on ptd_pkg.
`timescale 1ns / 1ps

interface ptd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [2:0]                task_index;
    logic [ptd_pkg::TIME_W-1:0] task_period;
    logic                      task_realtime;
    logic                      task_valid;
    logic [ptd_pkg::TIME_W-1:0] now_us;

    modport source (
        output valid, action, task_index, task_period, task_realtime, task_valid, now_us,
        input  ready
    );
    modport sink (
        input  valid, action, task_index, task_period, task_realtime, task_valid, now_us,
        output ready
    );
endinterface

// ----- sv/ptd_out_if.sv -----
// Result channel of the dispatcher: valid/ready plus one dispatch result.
// Depends on ptd_pkg.
`timescale 1ns / 1ps

interface ptd_out_if;
    logic                       valid;
    logic                       ready;
    logic [ptd_pkg::ID_W-1:0]   task_id;
    logic                       fired;
    logic [ptd_pkg::TIME_W-1:0] new_due_time;
    logic                       any_fired;
    logic                       last;

    modport source (
        output valid, task_id, fired, new_due_time, any_fired, last,
        input  ready
    );
    modport sink (
        input  valid, task_id, fired, new_due_time, any_fired, last,
        output ready
    );
endinterface

// ----- sv/periodic_task_dispatcher.sv -----
// Periodic task dispatcher. A load transaction writes one table entry
// (period, real-time flag, valid mark) and clears its due time; after
// the accept it runs the period/3 reciprocal multiply step, then the
// write step. A pass transaction walks all NUM_TASKS entries in index
// order with one shared 32-bit adder: an empty or not-yet-due entry
// takes only a check step, a due entry a check step (slip window) and
// then an update step (next due time). The update step waits while an
// earlier result cannot be passed on, the finish step while the result
// register is still full. Results come from an output register, so the
// last result may still wait while the next transaction is accepted.
// Each pass yields one result per dispatched task, or a single result
// with fired low when nothing was due; last marks the final one. The
// input is not ready while a transaction is in work.
// Depends on ptd_pkg, ptd_in_if, ptd_out_if, ptd_table, ptd_alu, ptd_ctrl.
`timescale 1ns / 1ps

module periodic_task_dispatcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptd_in_if.sink      i_task,
    ptd_out_if.source   o_result
);

    ptd_pkg::t_tbl_wr              tbl_wr;
    ptd_pkg::t_tbl_rd              tbl_rd;
    logic [ptd_pkg::IDX_W-1:0]     rd_addr;
    ptd_pkg::t_alu_op              alu_op;
    ptd_pkg::t_alu_res             alu_res;
    logic [ptd_pkg::TIME_W-1:0]    now;
    logic                          catch_up;

    // sequencer and result register
    ptd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_task    (i_task),
        .o_result  (o_result),
        .i_rd      (tbl_rd),
        .i_alu     (alu_res),
        .o_wr      (tbl_wr),
        .o_rd_addr (rd_addr),
        .o_alu_op  (alu_op),
        .o_now     (now),
        .o_catch   (catch_up)
    );

    // task table
    ptd_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd      (tbl_rd)
    );

    // shared adder
    ptd_alu u_alu (
        .i_op      (alu_op),
        .i_now     (now),
        .i_due     (tbl_rd.due),
        .i_third   (tbl_rd.third),
        .i_period  (tbl_rd.period),
        .i_catch   (catch_up),
        .o_res     (alu_res)
    );

endmodule

// ----- sv/ptd_table.sv -----
// Task table: period, period/3, real-time flag, valid mark and due time
// per entry. One write port, one read port. Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptd_pkg::t_tbl_wr              i_wr,
    input  logic [ptd_pkg::IDX_W-1:0]     i_rd_addr,
    output ptd_pkg::t_tbl_rd              o_rd
);

    logic [ptd_pkg::NUM_TASKS-1:0]   r_valid;
    logic [ptd_pkg::NUM_TASKS-1:0]   r_rt;
    logic [ptd_pkg::TIME_W-1:0]      r_period [ptd_pkg::NUM_TASKS];
    logic [ptd_pkg::TIME_W-1:0]      r_third  [ptd_pkg::NUM_TASKS];
    logic [ptd_pkg::TIME_W-1:0]      r_due    [ptd_pkg::NUM_TASKS];

    // valid marks: the only state reset needs, the payload of empty entries is never used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.load) begin
            r_valid[i_wr.addr] <= i_wr.valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_wr.load) begin
            r_rt[i_wr.addr]     <= i_wr.rt;
            r_period[i_wr.addr] <= i_wr.period;
            r_third[i_wr.addr]  <= i_wr.third;
            r_due[i_wr.addr]    <= i_wr.due;
        end else if (i_wr.upd) begin
            r_due[i_wr.addr]    <= i_wr.due;
        end
    end

    // read port
    always_comb begin
        o_rd.valid  = r_valid[i_rd_addr];
        o_rd.rt     = r_rt[i_rd_addr];
        o_rd.period = r_period[i_rd_addr];
        o_rd.third  = r_third[i_rd_addr];
        o_rd.due    = r_due[i_rd_addr];
    end

endmodule

// ----- sv/ptd_alu.sv -----
// Shared 32-bit adder with its compares, used twice per due task:
// once for the slip window, once for the next due time. Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_alu (
    input  ptd_pkg::t_alu_op             i_op,
    input  logic [ptd_pkg::TIME_W-1:0]   i_now,
    input  logic [ptd_pkg::TIME_W-1:0]   i_due,
    input  logic [ptd_pkg::TIME_W-1:0]   i_third,
    input  logic [ptd_pkg::TIME_W-1:0]   i_period,
    input  logic                         i_catch,
    output ptd_pkg::t_alu_res            o_res
);

    logic [ptd_pkg::TIME_W-1:0] opa;
    logic [ptd_pkg::TIME_W-1:0] opb;

    // operand select
    always_comb begin
        case (i_op)
            ptd_pkg::ALU_SLIP: begin
                opa = i_due;
                opb = i_third;
            end
            ptd_pkg::ALU_NEXT: begin
                opa = i_catch ? i_due : i_now;
                opb = i_period;
            end
            default: begin
                opa = i_due;
                opb = i_third;
            end
        endcase
    end

    // wrapping add, unsigned compares
    always_comb begin
        o_res.sum        = opa + opb;
        o_res.now_lt_sum = (i_now < o_res.sum);
        o_res.now_gt_due = (i_now > i_due);
    end

endmodule

// ----- sv/ptd_ctrl.sv -----
// Sequencer of the dispatcher: takes transactions, walks the table one
// entry per step, drives the shared adder and the result register.
// Depends on ptd_pkg, ptd_in_if, ptd_out_if.
`timescale 1ns / 1ps

module ptd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptd_in_if.sink                        i_task,
    ptd_out_if.source                     o_result,
    input  ptd_pkg::t_tbl_rd              i_rd,
    input  ptd_pkg::t_alu_res             i_alu,
    output ptd_pkg::t_tbl_wr              o_wr,
    output logic [ptd_pkg::IDX_W-1:0]     o_rd_addr,
    output ptd_pkg::t_alu_op              o_alu_op,
    output logic [ptd_pkg::TIME_W-1:0]    o_now,
    output logic                          o_catch
);

    ptd_pkg::t_state r_state;
    ptd_pkg::t_state n_state;

    // captured transaction
    logic [2:0]                  r_index;
    logic [ptd_pkg::TIME_W-1:0]  r_period;
    logic                        r_rt;
    logic                        r_valid;
    logic [ptd_pkg::TIME_W-1:0]  r_now;

    logic [ptd_pkg::PROD_W-1:0]  r_prod;
    logic [ptd_pkg::IDX_W-1:0]   r_idx;
    logic                        r_catch;

    // pending result, held until we know whether it is the last one
    logic                        r_pend_valid;
    logic [ptd_pkg::IDX_W-1:0]   r_pend_id;
    logic [ptd_pkg::TIME_W-1:0]  r_pend_due;

    // result register
    logic                        r_out_valid;
    logic [ptd_pkg::ID_W-1:0]    r_out_id;
    logic                        r_out_fired;
    logic [ptd_pkg::TIME_W-1:0]  r_out_due;
    logic                        r_out_any;
    logic                        r_out_last;

    logic in_fire;
    logic out_free;
    logic last_idx;
    logic load_ok;
    logic is_due;
    logic upd_go;
    logic push_pend;
    logic push_fin;

    assign in_fire  = i_task.valid && i_task.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign last_idx = (r_idx == ptd_pkg::IDX_W'(ptd_pkg::NUM_TASKS - 1));
    assign load_ok  = (32'(r_index) < 32'(ptd_pkg::NUM_TASKS));
    assign is_due   = i_rd.valid && i_alu.now_gt_due;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptd_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_task.action == ptd_pkg::ACT_LOAD) ?
                              ptd_pkg::S_LOAD_MUL : ptd_pkg::S_CHECK;
                end
            end
            ptd_pkg::S_LOAD_MUL: n_state = ptd_pkg::S_LOAD_WR;
            ptd_pkg::S_LOAD_WR:  n_state = ptd_pkg::S_IDLE;
            ptd_pkg::S_CHECK: begin
                if (is_due) begin
                    n_state = ptd_pkg::S_UPDATE;
                end else if (last_idx) begin
                    n_state = ptd_pkg::S_FINISH;
                end
            end
            ptd_pkg::S_UPDATE: begin
                if (!r_pend_valid || out_free) begin
                    n_state = last_idx ? ptd_pkg::S_FINISH : ptd_pkg::S_CHECK;
                end
            end
            ptd_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = ptd_pkg::S_IDLE;
                end
            end
            default: n_state = ptd_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        upd_go    = (r_state == ptd_pkg::S_UPDATE) && (!r_pend_valid || out_free);
        push_pend = upd_go && r_pend_valid;
        push_fin  = (r_state == ptd_pkg::S_FINISH) && out_free;

        o_alu_op  = (r_state == ptd_pkg::S_UPDATE) ? ptd_pkg::ALU_NEXT : ptd_pkg::ALU_SLIP;
        o_rd_addr = r_idx;
        o_now     = r_now;
        o_catch   = r_catch;

        o_wr.load   = (r_state == ptd_pkg::S_LOAD_WR) && load_ok;
        o_wr.upd    = upd_go;
        o_wr.addr   = o_wr.load ? ptd_pkg::IDX_W'(r_index) : r_idx;
        o_wr.period = r_period;
        o_wr.third  = ptd_pkg::TIME_W'(r_prod >> ptd_pkg::THIRD_SHIFT);
        o_wr.rt     = r_rt;
        o_wr.valid  = r_valid;
        o_wr.due    = o_wr.load ? '0 : i_alu.sum;

        i_task.ready = (r_state == ptd_pkg::S_IDLE);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptd_pkg::S_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // table walk index
            if (in_fire) begin
                r_idx <= '0;
            end else if (((r_state == ptd_pkg::S_CHECK) && !is_due) || upd_go) begin
                if (!last_idx) begin
                    r_idx <= r_idx + ptd_pkg::IDX_W'(1);
                end
            end

            // pending result
            if (in_fire || push_fin) begin
                r_pend_valid <= 1'b0;
            end else if (upd_go) begin
                r_pend_valid <= 1'b1;
            end

            // result register handshake
            if (push_pend || push_fin) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_index  <= i_task.task_index;
            r_period <= i_task.task_period;
            r_rt     <= i_task.task_realtime;
            r_valid  <= i_task.task_valid;
            r_now    <= i_task.now_us;
        end

        // period/3 by reciprocal multiply, sliced in the write state
        if (r_state == ptd_pkg::S_LOAD_MUL) begin
            r_prod <= ptd_pkg::PROD_W'(r_period) * ptd_pkg::PROD_W'(ptd_pkg::THIRD_RECIP);
        end

        // slip window verdict for the due entry
        if (r_state == ptd_pkg::S_CHECK) begin
            r_catch <= i_rd.rt && i_alu.now_lt_sum;
        end

        if (upd_go) begin
            r_pend_id  <= r_idx;
            r_pend_due <= i_alu.sum;
        end

        if (push_pend) begin
            r_out_id    <= ptd_pkg::ID_W'(r_pend_id);
            r_out_fired <= 1'b1;
            r_out_due   <= r_pend_due;
            r_out_any   <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (push_fin) begin
            r_out_id    <= r_pend_valid ? ptd_pkg::ID_W'(r_pend_id) : '0;
            r_out_fired <= r_pend_valid;
            r_out_due   <= r_pend_valid ? r_pend_due : '0;
            r_out_any   <= r_pend_valid;
            r_out_last  <= 1'b1;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.task_id      = r_out_id;
    assign o_result.fired        = r_out_fired;
    assign o_result.new_due_time = r_out_due;
    assign o_result.any_fired    = r_out_any;
    assign o_result.last         = r_out_last;

endmodule

// ----- sv/ptd_checker.sv -----
// Port-level checks for the periodic task dispatcher, bound to the top.
// Depends on ptd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_action,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [ptd_pkg::ID_W-1:0]    i_out_id,
    input logic                        i_out_fired,
    input logic [ptd_pkg::TIME_W-1:0]  i_out_due,
    input logic                        i_out_any,
    input logic                        i_out_last
);

    // the input is not ready in the cycle after a pass is accepted
    `PTD_ASSERT_NEXT(a_pass_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_action == ptd_pkg::ACT_PASS), !i_in_ready)

    // a no-dispatch result is the lone, zeroed closing result
    `PTD_ASSERT_IMPLY(a_idle_result, i_clk, i_rst_n, i_out_valid && !i_out_fired, i_out_last && !i_out_any && (i_out_due == '0) && (i_out_id == '0))

    // among dispatch results, any_fired marks exactly the closing one
    `PTD_ASSERT_IMPLY(a_any_on_last, i_clk, i_rst_n, i_out_valid && i_out_fired, i_out_any == i_out_last)

    // a stalled result holds
    `PTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_id) && $stable(i_out_due) && $stable(i_out_last))

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_task.valid),
    .i_in_ready  (i_task.ready),
    .i_in_action (i_task.action),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_id    (o_result.task_id),
    .i_out_fired (o_result.fired),
    .i_out_due   (o_result.new_due_time),
    .i_out_any   (o_result.any_fired),
    .i_out_last  (o_result.last)
);
